/* rtl/rai_pkg.sv */
// shared types, widths and register codes for the ray/annulus intersection block
package rai_pkg;

  localparam int COORD_W      = 32;
  localparam int FRAC_BITS_DF = 16;
  localparam int CFG_IDX_W    = 3;
  localparam int CFG_DATA_W   = 32;

  typedef enum logic [CFG_IDX_W-1:0] {
    CFG_CENTER_X = 3'd0,
    CFG_CENTER_Y = 3'd1,
    CFG_CENTER_Z = 3'd2,
    CFG_NORMAL_X = 3'd3,
    CFG_NORMAL_Y = 3'd4,
    CFG_NORMAL_Z = 3'd5,
    CFG_INNER_SQ = 3'd6,
    CFG_OUTER_SQ = 3'd7
  } rai_cfg_e;

  typedef struct packed {
    logic signed [COORD_W-1:0] origin_x;
    logic signed [COORD_W-1:0] origin_y;
    logic signed [COORD_W-1:0] origin_z;
    logic signed [COORD_W-1:0] dir_x;
    logic signed [COORD_W-1:0] dir_y;
    logic signed [COORD_W-1:0] dir_z;
  } rai_ray_t;

  typedef struct packed {
    logic                      is_hit;
    logic        [COORD_W-2:0] hit_distance;
    logic signed [COORD_W-1:0] point_x;
    logic signed [COORD_W-1:0] point_y;
    logic signed [COORD_W-1:0] point_z;
  } rai_res_t;

  // per-stage control that travels along the divider chain
  typedef struct packed {
    logic valid;
    logic miss;
  } rai_ctl_t;

endpackage

/* rtl/ray_annulus_intersect_top.sv */
// top level of the ray/annulus intersection pipeline
// Usage:
//   Rays enter on in_i, taken at each rising edge with start high; busy is
//   always low, so a new ray may be offered in every cycle.
//   Each ray gives exactly one result on res_o, shown for one cycle with
//   done_o high. Results leave in the order the rays came in.
//   Three stages form the plane distance numerator and denominator, a chain
//   of COORD_W division cells resolves one quotient bit each, and four stages
//   form the hit point and the ring test. Throughput is one ray per cycle.
//   Configuration goes through cfg_valid_i/cfg_ready_o with a register index
//   and data; cfg_ready_o is always high. Registers may only change while no
//   ray is in flight.
//   Reset clears all pipeline valid bits and loads the registers with center
//   at the origin, normal along +y, inner radius squared 0.64, outer 1.0.
//   The receiver cannot stall: a result is gone after its strobe cycle.
module ray_annulus_intersect_top #(
  parameter int FRAC_BITS = rai_pkg::FRAC_BITS_DF
) (
  input  logic                               clk_i,
  input  logic                               rst_ni,
  input  logic                               start,
  output logic                               busy,
  input  rai_pkg::rai_ray_t                  in_i,
  output logic                               done_o,
  output rai_pkg::rai_res_t                  res_o,
  input  logic                               cfg_valid_i,
  output logic                               cfg_ready_o,
  input  logic [rai_pkg::CFG_IDX_W-1:0]      cfg_index_i,
  input  logic [rai_pkg::CFG_DATA_W-1:0]     cfg_data_i
);
  import rai_pkg::*;

  localparam int W     = COORD_W;
  localparam int F     = FRAC_BITS;
  localparam int NW    = F + 2;
  localparam int PNW   = W + 1 + NW;
  localparam int PDW   = W + NW;
  localparam int NUMW  = PNW + 2;
  localparam int DENW  = PDW + 2;
  localparam int RW    = NUMW + F;
  localparam int SQW   = 2 * W + 2;
  localparam int DSQW  = SQW + 2;
  localparam int EPS_T = ((1 << F) + 5000) / 10000;
  localparam int INNER_RST = ((64 << F) + 50) / 100;
  localparam logic [W-2:0] TMAX = '1;

  // configuration registers
  logic signed [W-1:0]  cen_q [3];
  logic signed [NW-1:0] nrm_q [3];
  logic        [W-2:0]  inner_q, outer_q;

  assign cfg_ready_o = 1'b1;
  assign busy        = 1'b0;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      cen_q[0] <= '0;
      cen_q[1] <= '0;
      cen_q[2] <= '0;
      nrm_q[0] <= '0;
      nrm_q[1] <= NW'(1 << F);
      nrm_q[2] <= '0;
      inner_q  <= (W-1)'(INNER_RST);
      outer_q  <= (W-1)'(1 << F);
    end else if (cfg_valid_i) begin
      case (rai_cfg_e'(cfg_index_i))
        CFG_CENTER_X: cen_q[0] <= cfg_data_i[W-1:0];
        CFG_CENTER_Y: cen_q[1] <= cfg_data_i[W-1:0];
        CFG_CENTER_Z: cen_q[2] <= cfg_data_i[W-1:0];
        CFG_NORMAL_X: nrm_q[0] <= cfg_data_i[NW-1:0];
        CFG_NORMAL_Y: nrm_q[1] <= cfg_data_i[NW-1:0];
        CFG_NORMAL_Z: nrm_q[2] <= cfg_data_i[NW-1:0];
        CFG_INNER_SQ: inner_q  <= cfg_data_i[W-2:0];
        CFG_OUTER_SQ: outer_q  <= cfg_data_i[W-2:0];
        default: ;
      endcase
    end
  end

  // stage 1: per-axis products
  logic signed [W-1:0]   org_1 [3];
  logic signed [W-1:0]   dir_1 [3];
  logic signed [W:0]     dif_1 [3];
  logic signed [PNW-1:0] pn_d [3], pn_q [3];
  logic signed [PDW-1:0] pd_d [3], pd_q [3];
  logic                  v1_q;
  rai_ray_t              ray1_q;

  always_comb begin
    org_1[0] = in_i.origin_x;
    org_1[1] = in_i.origin_y;
    org_1[2] = in_i.origin_z;
    dir_1[0] = in_i.dir_x;
    dir_1[1] = in_i.dir_y;
    dir_1[2] = in_i.dir_z;
    for (int a = 0; a < 3; a++) begin
      dif_1[a] = $signed({cen_q[a][W-1], cen_q[a]}) - $signed({org_1[a][W-1], org_1[a]});
      pn_d[a]  = PNW'(dif_1[a]) * PNW'(nrm_q[a]);
      pd_d[a]  = PDW'(dir_1[a]) * PDW'(nrm_q[a]);
    end
  end

  // stage 2: dot products
  logic signed [NUMW-1:0] num_d, num_q;
  logic signed [DENW-1:0] den_d, den_q;
  logic                   v2_q;
  rai_ray_t               ray2_q;

  always_comb begin
    num_d = NUMW'(pn_q[0]) + NUMW'(pn_q[1]) + NUMW'(pn_q[2]);
    den_d = DENW'(pd_q[0]) + DENW'(pd_q[1]) + DENW'(pd_q[2]);
  end

  // stage 3: signs and magnitudes for the divider
  logic [NUMW-1:0] anum;
  logic [DENW-1:0] aden;
  logic            miss3;

  always_comb begin
    anum  = num_q[NUMW-1] ? NUMW'(-num_q) : NUMW'(num_q);
    aden  = den_q[DENW-1] ? DENW'(-den_q) : DENW'(den_q);
    miss3 = (den_q == '0) || (num_q[NUMW-1] != den_q[DENW-1]);
  end

  // divider chain
  rai_ctl_t        ctl_s [W+1];
  rai_ray_t        ray_s [W+1];
  logic [RW-1:0]   rem_s [W+1];
  logic [DENW-1:0] div_s [W+1];
  logic [W-1:0]    quo_s [W+1];

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      v1_q     <= 1'b0;
      v2_q     <= 1'b0;
      ctl_s[0] <= '0;
    end else begin
      v1_q           <= start & ~busy;
      v2_q           <= v1_q;
      ctl_s[0].valid <= v2_q;
      ctl_s[0].miss  <= miss3;
    end
  end

  always_ff @(posedge clk_i) begin
    ray1_q   <= in_i;
    pn_q     <= pn_d;
    pd_q     <= pd_d;
    ray2_q   <= ray1_q;
    num_q    <= num_d;
    den_q    <= den_d;
    ray_s[0] <= ray2_q;
    rem_s[0] <= {anum, {F{1'b0}}};
    div_s[0] <= aden;
    quo_s[0] <= '0;
  end

  for (genvar k = 0; k < W; k++) begin : g_cell
    rai_div_cell #(
      .RW   (RW),
      .DW   (DENW),
      .QW   (W),
      .SHIFT(W - 1 - k)
    ) u_cell (
      .clk_i (clk_i),
      .rst_ni(rst_ni),
      .ctl_i (ctl_s[k]),
      .ray_i (ray_s[k]),
      .rem_i (rem_s[k]),
      .div_i (div_s[k]),
      .quo_i (quo_s[k]),
      .ctl_o (ctl_s[k+1]),
      .ray_o (ray_s[k+1]),
      .rem_o (rem_s[k+1]),
      .div_o (div_s[k+1]),
      .quo_o (quo_s[k+1])
    );
  end

  // stage 4: saturate t, epsilon test, t*d
  logic [W-1:0]          quo;
  logic                  sat;
  logic [W-2:0]          t_d, t4_q;
  logic                  miss4_d;
  logic signed [W-1:0]   dir_4 [3];
  logic signed [2*W-1:0] td_d [3], td_q [3];
  logic                  v4_q, miss4_q;
  rai_ray_t              ray4_q;

  always_comb begin
    quo      = quo_s[W];
    sat      = quo[W-1];
    t_d      = sat ? TMAX : quo[W-2:0];
    miss4_d  = ctl_s[W].miss | (~sat & (quo <= W'(EPS_T)));
    dir_4[0] = ray_s[W].dir_x;
    dir_4[1] = ray_s[W].dir_y;
    dir_4[2] = ray_s[W].dir_z;
    for (int a = 0; a < 3; a++) begin
      td_d[a] = $signed({{(W+1){1'b0}}, t_d}) * (2*W)'(dir_4[a]);
    end
  end

  // stage 5: hit point with saturation
  logic signed [W-1:0]   org_5 [3];
  logic signed [2*W-1:0] sh_5 [3];
  logic signed [2*W:0]   v_5 [3];
  logic signed [W-1:0]   p_d [3], p_q [3];
  logic                  over, under;
  logic [W-2:0]          t5_q;
  logic                  v5_q, miss5_q;

  always_comb begin
    org_5[0] = ray4_q.origin_x;
    org_5[1] = ray4_q.origin_y;
    org_5[2] = ray4_q.origin_z;
    over     = 1'b0;
    under    = 1'b0;
    for (int a = 0; a < 3; a++) begin
      sh_5[a] = td_q[a] >>> F;
      v_5[a]  = (2*W+1)'(org_5[a]) + (2*W+1)'(sh_5[a]);
      over    = ~v_5[a][2*W] & (v_5[a][2*W-1:W-1] != '0);
      under   = v_5[a][2*W] & (v_5[a][2*W-1:W-1] != '1);
      if (over) begin
        p_d[a] = {1'b0, {(W-1){1'b1}}};
      end else if (under) begin
        p_d[a] = {1'b1, {(W-1){1'b0}}};
      end else begin
        p_d[a] = v_5[a][W-1:0];
      end
    end
  end

  // stage 6: squared offsets from the center
  logic signed [W:0]     df_6 [3];
  logic signed [SQW-1:0] sq_d [3], sq_q [3];
  logic signed [W-1:0]   p6_q [3];
  logic [W-2:0]          t6_q;
  logic                  v6_q, miss6_q;

  always_comb begin
    for (int a = 0; a < 3; a++) begin
      df_6[a] = $signed({p_q[a][W-1], p_q[a]}) - $signed({cen_q[a][W-1], cen_q[a]});
      sq_d[a] = SQW'(df_6[a]) * SQW'(df_6[a]);
    end
  end

  // stage 7: ring test and result register
  logic [DSQW-1:0] dsq, lo_b, hi_b;
  logic            hit;
  rai_res_t        res_d, res_q;
  logic            done_q;

  always_comb begin
    dsq  = DSQW'(sq_q[0]) + DSQW'(sq_q[1]) + DSQW'(sq_q[2]);
    lo_b = DSQW'(inner_q) << F;
    hi_b = DSQW'(outer_q) << F;
    hit  = ~miss6_q & (lo_b < dsq) & (dsq < hi_b);
    res_d.is_hit       = hit;
    res_d.hit_distance = hit ? t6_q : '0;
    res_d.point_x      = hit ? p6_q[0] : '0;
    res_d.point_y      = hit ? p6_q[1] : '0;
    res_d.point_z      = hit ? p6_q[2] : '0;
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      v4_q   <= 1'b0;
      v5_q   <= 1'b0;
      v6_q   <= 1'b0;
      done_q <= 1'b0;
    end else begin
      v4_q   <= ctl_s[W].valid;
      v5_q   <= v4_q;
      v6_q   <= v5_q;
      done_q <= v6_q;
    end
  end

  always_ff @(posedge clk_i) begin
    t4_q    <= t_d;
    miss4_q <= miss4_d;
    td_q    <= td_d;
    ray4_q  <= ray_s[W];
    p_q     <= p_d;
    t5_q    <= t4_q;
    miss5_q <= miss4_q;
    sq_q    <= sq_d;
    p6_q    <= p_q;
    t6_q    <= t5_q;
    miss6_q <= miss5_q;
    res_q   <= res_d;
  end

  assign done_o = done_q;
  assign res_o  = res_q;

endmodule

/* rtl/rai_div_cell.sv */
// one restoring-division cell: decides one quotient bit and passes the item on
module rai_div_cell #(
  parameter int RW    = 69,
  parameter int DW    = 52,
  parameter int QW    = 32,
  parameter int SHIFT = 0
) (
  input  logic              clk_i,
  input  logic              rst_ni,
  input  rai_pkg::rai_ctl_t ctl_i,
  input  rai_pkg::rai_ray_t ray_i,
  input  logic [RW-1:0]     rem_i,
  input  logic [DW-1:0]     div_i,
  input  logic [QW-1:0]     quo_i,
  output rai_pkg::rai_ctl_t ctl_o,
  output rai_pkg::rai_ray_t ray_o,
  output logic [RW-1:0]     rem_o,
  output logic [DW-1:0]     div_o,
  output logic [QW-1:0]     quo_o
);
  import rai_pkg::*;

  localparam int CW = ((DW + SHIFT) > RW) ? (DW + SHIFT + 1) : (RW + 1);

  logic [CW-1:0] rem_x, div_x, diff;
  logic          ge;
  rai_ctl_t      ctl_q;
  rai_ray_t      ray_q;
  logic [RW-1:0] rem_d, rem_q;
  logic [DW-1:0] div_q;
  logic [QW-1:0] quo_d, quo_q;

  always_comb begin
    rem_x = CW'(rem_i);
    div_x = CW'(div_i) << SHIFT;
    diff  = rem_x - div_x;
    ge    = ~diff[CW-1];
    rem_d = ge ? diff[RW-1:0] : rem_i;
    quo_d = {quo_i[QW-2:0], ge};
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      ctl_q <= '0;
    end else begin
      ctl_q <= ctl_i;
    end
  end

  always_ff @(posedge clk_i) begin
    ray_q <= ray_i;
    rem_q <= rem_d;
    div_q <= div_i;
    quo_q <= quo_d;
  end

  assign ctl_o = ctl_q;
  assign ray_o = ray_q;
  assign rem_o = rem_q;
  assign div_o = div_q;
  assign quo_o = quo_q;

endmodule

/* verif/ray_annulus_intersect_top_tb.sv */
// self-checking testbench for the ray/annulus intersection pipeline
module ray_annulus_intersect_top_tb;
  import rai_pkg::*;

  localparam int LATENCY = COORD_W + 7;
  localparam int CYCLE_LIMIT = 400000;
  localparam logic [127:0] EPS_T = 128'd7;
  localparam logic [127:0] T_MAX = 128'h7fffffff;
  localparam logic signed [127:0] P_MAX = 128'sh7fffffff;
  localparam logic signed [127:0] P_MIN = -(128'sd1 <<< 31);

  logic clk = 1'b0;
  logic rst_n = 1'b0;
  logic start = 1'b0;
  logic busy;
  rai_ray_t ray_in = '0;
  logic done;
  rai_res_t res;
  logic cfg_valid = 1'b0;
  logic cfg_ready;
  logic [CFG_IDX_W-1:0] cfg_index = '0;
  logic [CFG_DATA_W-1:0] cfg_data = '0;

  // shadow copy of the ring configuration
  logic signed [31:0] ctr [3];
  logic signed [17:0] nrm [3];
  logic [30:0] inner_sq, outer_sq;

  rai_ray_t pending_rays[$];
  rai_res_t expected_hits[$];
  int sender_idle_pct = 0;
  int mismatches = 0;
  int cycles = 0;

  ray_annulus_intersect_top dut (
    .clk_i(clk), .rst_ni(rst_n), .start(start), .busy(busy), .in_i(ray_in),
    .done_o(done), .res_o(res), .cfg_valid_i(cfg_valid), .cfg_ready_o(cfg_ready),
    .cfg_index_i(cfg_index), .cfg_data_i(cfg_data)
  );

  always #10 clk = ~clk;

  function automatic rai_res_t predict_hit(rai_ray_t r);
    logic signed [127:0] num, den, prod, v, dsq, lo_b, hi_b, diff;
    logic signed [127:0] cc [3], nv [3], oo [3], dd [3], pp [3];
    logic [127:0] un, ud, q;
    logic [30:0] t;
    rai_res_t hit;
    hit = '0;
    oo[0] = $signed(r.origin_x); oo[1] = $signed(r.origin_y); oo[2] = $signed(r.origin_z);
    dd[0] = $signed(r.dir_x); dd[1] = $signed(r.dir_y); dd[2] = $signed(r.dir_z);
    num = 0;
    den = 0;
    dsq = 0;
    for (int a = 0; a < 3; a++) begin
      cc[a] = ctr[a];
      nv[a] = nrm[a];
      num = num + (cc[a] - oo[a]) * nv[a];
      den = den + dd[a] * nv[a];
    end
    if (den == 0) return hit;
    if ((num < 0) != (den < 0)) return hit;
    un = (num < 0) ? -num : num;
    ud = (den < 0) ? -den : den;
    q = (un << 16) / ud;
    if (q <= EPS_T) return hit;
    t = (q > T_MAX) ? T_MAX[30:0] : q[30:0];
    for (int a = 0; a < 3; a++) begin
      prod = $signed({97'b0, t}) * dd[a];
      v = oo[a] + (prod >>> 16);
      if (v > P_MAX) pp[a] = P_MAX;
      else if (v < P_MIN) pp[a] = P_MIN;
      else pp[a] = v;
      diff = pp[a] - cc[a];
      dsq = dsq + diff * diff;
    end
    lo_b = $signed({97'b0, inner_sq}) <<< 16;
    hi_b = $signed({97'b0, outer_sq}) <<< 16;
    if (lo_b < dsq && dsq < hi_b) begin
      hit.is_hit = 1'b1;
      hit.hit_distance = t;
      hit.point_x = pp[0][31:0];
      hit.point_y = pp[1][31:0];
      hit.point_z = pp[2][31:0];
    end
    return hit;
  endfunction

  // driver: offers queued rays, holding each until taken
  always @(posedge clk) begin
    cycles <= cycles + 1;
    if (rst_n) begin
      if (start && !busy) begin
        expected_hits.push_back(predict_hit(pending_rays[0]));
        void'(pending_rays.pop_front());
      end
      if (!(start && busy)) begin
        if ((start && !busy ? pending_rays.size() > 0 : pending_rays.size() > 0) &&
            $urandom_range(99) >= sender_idle_pct) begin
          start <= 1'b1;
          ray_in <= pending_rays[0];
        end else begin
          start <= 1'b0;
        end
      end
    end
  end

  // monitor: every strobed result against the oldest prediction
  always @(posedge clk) begin
    rai_res_t exp_r;
    if (rst_n && done) begin
      if (expected_hits.size() == 0) begin
        mismatches <= mismatches + 1;
        if (mismatches < 10) $display("unexpected result %h", res);
      end else begin
        exp_r = expected_hits.pop_front();
        if (res.is_hit !== exp_r.is_hit || res.hit_distance !== exp_r.hit_distance ||
            res.point_x !== exp_r.point_x || res.point_y !== exp_r.point_y ||
            res.point_z !== exp_r.point_z) begin
          mismatches <= mismatches + 1;
          if (mismatches < 10)
            $display("mismatch: expected hit=%0d t=%h p=(%h %h %h) got hit=%0d t=%h p=(%h %h %h)",
                     exp_r.is_hit, exp_r.hit_distance, exp_r.point_x, exp_r.point_y,
                     exp_r.point_z, res.is_hit, res.hit_distance, res.point_x,
                     res.point_y, res.point_z);
        end
      end
    end
    if (cycles > CYCLE_LIMIT) begin
      $display("FAIL");
      $finish;
    end
  end

  task automatic write_reg(rai_cfg_e idx, logic [31:0] data);
    @(posedge clk);
    cfg_valid <= 1'b1;
    cfg_index <= idx;
    cfg_data <= data;
    do @(posedge clk); while (!cfg_ready);
    case (idx)
      CFG_CENTER_X: ctr[0] = data;
      CFG_CENTER_Y: ctr[1] = data;
      CFG_CENTER_Z: ctr[2] = data;
      CFG_NORMAL_X: nrm[0] = data[17:0];
      CFG_NORMAL_Y: nrm[1] = data[17:0];
      CFG_NORMAL_Z: nrm[2] = data[17:0];
      CFG_INNER_SQ: inner_sq = data[30:0];
      CFG_OUTER_SQ: outer_sq = data[30:0];
      default: ;
    endcase
    cfg_valid <= 1'b0;
  endtask

  function automatic rai_ray_t mk_ray(int ox, int oy, int oz, int dx, int dy, int dz);
    rai_ray_t r;
    r.origin_x = ox; r.origin_y = oy; r.origin_z = oz;
    r.dir_x = dx; r.dir_y = dy; r.dir_z = dz;
    return r;
  endfunction

  function automatic logic [31:0] near_val(int span);
    return $urandom_range(2 * span) - span;
  endfunction

  task automatic queue_random(int count);
    rai_ray_t r;
    for (int i = 0; i < count; i++) begin
      if ($urandom_range(99) < 70)
        // aimed rays: modest origin and direction near the ring
        r = mk_ray(ctr[0] + near_val(262144), ctr[1] + near_val(262144),
                   ctr[2] + near_val(262144), near_val(131072), near_val(131072),
                   near_val(131072));
      else
        r = {$urandom, $urandom, $urandom, $urandom, $urandom, $urandom};
      pending_rays.push_back(r);
    end
  endtask

  task automatic drain;
    wait (pending_rays.size() == 0 && !start && expected_hits.size() == 0);
    repeat (LATENCY + 5) @(posedge clk);
  endtask

  initial begin
    ctr[0] = 0; ctr[1] = 0; ctr[2] = 0;
    nrm[0] = 0; nrm[1] = 18'd65536; nrm[2] = 0;
    inner_sq = 31'd41943;
    outer_sq = 31'd65536;
    repeat (3) @(posedge clk);
    rst_n <= 1'b1;
    repeat (2) @(posedge clk);

    // directed rays against the reset ring
    pending_rays.push_back(mk_ray(58982, -65536, 0, 0, 65536, 0));   // ring hit
    pending_rays.push_back(mk_ray(0, -65536, 0, 0, 65536, 0));       // hole
    pending_rays.push_back(mk_ray(131072, -65536, 0, 0, 65536, 0));  // outside
    pending_rays.push_back(mk_ray(58982, -65536, 0, 65536, 0, 0));   // parallel
    pending_rays.push_back(mk_ray(58982, -65536, 0, 0, -65536, 0));  // behind
    pending_rays.push_back(mk_ray(58982, -7, 0, 0, 65536, 0));       // t at epsilon
    pending_rays.push_back(mk_ray(58982, -8, 0, 0, 65536, 0));       // just past epsilon
    pending_rays.push_back(mk_ray(58982, 0, 0, 0, 65536, 0));        // zero t
    pending_rays.push_back(mk_ray(0, 32'h80000000, 0, 0, 1, 0));     // saturated t
    pending_rays.push_back(mk_ray(0, -65536, 0, 32'h7fffffff, 1, 32'h80000000));
    pending_rays.push_back(mk_ray(32'h7fffffff, 32'h7fffffff, 32'h7fffffff,
                                  32'h7fffffff, 32'h7fffffff, 32'h7fffffff));
    pending_rays.push_back(mk_ray(32'h80000000, 32'h80000000, 32'h80000000,
                                  32'h80000000, 32'h80000000, 32'h80000000));
    pending_rays.push_back(mk_ray(-1, -1, -1, -1, -1, -1));
    pending_rays.push_back(mk_ray(0, 0, 0, 0, 0, 0));
    pending_rays.push_back(mk_ray(45000, -65536, 45000, 0, 65536, 0));
    drain();

    sender_idle_pct = 0;
    queue_random(400);
    drain();

    write_reg(CFG_NORMAL_Y, 32'd0);
    write_reg(CFG_NORMAL_X, 32'd65536);
    write_reg(CFG_CENTER_X, 32'd131072);
    write_reg(CFG_INNER_SQ, 32'd0);
    write_reg(CFG_OUTER_SQ, 32'd262144);
    sender_idle_pct = 55;
    queue_random(400);
    drain();

    write_reg(CFG_NORMAL_X, 32'd46341);
    write_reg(CFG_NORMAL_Z, 32'h3ffff & -32'd46341);
    write_reg(CFG_CENTER_Y, -32'd196608);
    write_reg(CFG_CENTER_Z, 32'd65536);
    write_reg(CFG_INNER_SQ, 32'd65536);
    write_reg(CFG_OUTER_SQ, 32'd1048576);
    sender_idle_pct = 34;
    queue_random(400);
    drain();

    // extremes of every register
    write_reg(CFG_CENTER_X, 32'h7fffffff);
    write_reg(CFG_CENTER_Y, 32'h80000000);
    write_reg(CFG_CENTER_Z, 32'h7fffffff);
    write_reg(CFG_NORMAL_X, 32'hfffd0000);
    write_reg(CFG_NORMAL_Y, 32'h0001ffff);
    write_reg(CFG_NORMAL_Z, 32'h00020000);
    write_reg(CFG_INNER_SQ, 32'd0);
    write_reg(CFG_OUTER_SQ, 32'hffffffff);
    sender_idle_pct = 0;
    queue_random(300);
    drain();

    write_reg(CFG_CENTER_X, 32'd0);
    write_reg(CFG_CENTER_Y, 32'd0);
    write_reg(CFG_CENTER_Z, 32'd0);
    write_reg(CFG_NORMAL_X, 32'd0);
    write_reg(CFG_NORMAL_Y, 32'hffff0000);
    write_reg(CFG_NORMAL_Z, 32'd0);
    write_reg(CFG_INNER_SQ, 32'h7fffffff);
    write_reg(CFG_OUTER_SQ, 32'd0);
    sender_idle_pct = 55;
    queue_random(100);
    drain();

    write_reg(CFG_INNER_SQ, 32'd16384);
    write_reg(CFG_OUTER_SQ, 32'd4194304);
    sender_idle_pct = 34;
    queue_random(400);
    drain();

    if (mismatches == 0) begin
      $display("PASS");
    end else begin
      $display("FAIL");
    end
    $finish;
  end

endmodule
